/* src/szpd_pkg.sv */
// Shared types and constants for the smoothed z-score peak detector.
// No dependencies; used by szpd_mul_unit and the top level.
package szpd_pkg;

  // Default window length
  localparam int LAG_DEFAULT = 10;

  // Shared multiplier: A is fed in chunks of A_W bits, B is up to B_W bits.
  // Sized for the longest window (64): two A chunks cover every operand.
  localparam int A_W   = 24;
  localparam int B_W   = 32;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = 2 * A_W + B_W;

  // Configuration register indexes (address bit 2)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_INFLUENCE = 1'b1;

  localparam int THR_W = 12;
  localparam int INF_W = 9;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd640;
  localparam logic [INF_W-1:0] INFLUENCE_RESET = 9'd205;
  localparam logic [INF_W-1:0] INFLUENCE_FULL  = 9'd256;

  // Command to the shared multiplier
  typedef struct packed {
    logic en;  // perform a pass this cycle
    logic hi;  // 1: add product shifted by A_W, 0: load product
  } mul_ctrl_t;

endpackage

/* src/szpd_mul_unit.sv */
// Shared multiply-accumulate unit of the peak detector.
// One A_W x B_W multiplier; a two-pass op forms a 2*A_W x B_W product.
// Depends on szpd_pkg.
module szpd_mul_unit (
  input  logic                          clk,
  input  szpd_pkg::mul_ctrl_t           ctrl,
  input  logic [szpd_pkg::A_W-1:0]      a,
  input  logic [szpd_pkg::B_W-1:0]      b,
  output logic [szpd_pkg::ACC_W-1:0]    acc
);
  import szpd_pkg::*;

  logic [P_W-1:0] prod;

  assign prod = P_W'(a) * P_W'(b);

  // low pass loads, high pass adds the upper partial product
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (ctrl.hi) begin
        acc <= acc + (ACC_W'(prod) << A_W);
      end else begin
        acc <= ACC_W'(prod);
      end
    end
  end

endmodule

/* src/smoothed_zscore_peak_detector_unit.sv */
// Smoothed z-score peak detector: one signed 16-bit sample in, one signal out.
// Depends on szpd_pkg and szpd_mul_unit.
//
// Each sample item gives one result item (peak_signal +1/-1/0, warming_up).
// The first LAG samples fill the window and take only the filter, square and
// done steps; later samples run the whole sequence of passes through the
// one shared 24x32 multiplier (window sum squared, scaled square sum, threshold
// squared and scaled, variance product, deviation squared and scaled, blend,
// and the two squares for the running sum of squares). A finished result waits
// in an output register; the next sample is taken meanwhile and stalls only in
// its done step if the previous result is still untaken. The window ring is a
// LAG-entry memory with one write and one registered read port. Registers at
// byte 0 (threshold, Q4.8) and byte 4 (influence, Q1.8) of the APB port.
module smoothed_zscore_peak_detector_unit #(
  parameter int LAG = szpd_pkg::LAG_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [1:0]  peak_signal,
  output logic               warming_up,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import szpd_pkg::*;

  localparam int LAG_W  = $clog2(LAG);
  localparam int FILL_W = $clog2(LAG + 1);
  localparam int SUM_W  = 16 + $clog2(LAG);
  localparam int SQ_W   = 31 + $clog2(LAG);
  localparam int D_W    = 18 + $clog2(LAG);
  localparam int CMP_W  = ACC_W + 16;
  localparam int BL_W   = 27;
  localparam logic signed [D_W-1:0] LAG_SD = D_W'(LAG);

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_SQS    = 16'b0000_0000_0000_0010,
    S_LSS_LO = 16'b0000_0000_0000_0100,
    S_LSS_HI = 16'b0000_0000_0000_1000,
    S_T2     = 16'b0000_0000_0001_0000,
    S_TL     = 16'b0000_0000_0010_0000,
    S_RHS_LO = 16'b0000_0000_0100_0000,
    S_RHS_HI = 16'b0000_0000_1000_0000,
    S_D2     = 16'b0000_0001_0000_0000,
    S_LHS_LO = 16'b0000_0010_0000_0000,
    S_LHS_HI = 16'b0000_0100_0000_0000,
    S_BLEND  = 16'b0000_1000_0000_0000,
    S_FILT   = 16'b0001_0000_0000_0000,
    S_FSQ    = 16'b0010_0000_0000_0000,
    S_OSQ    = 16'b0100_0000_0000_0000,
    S_DONE   = 16'b1000_0000_0000_0000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [THR_W-1:0] threshold;
  logic [INF_W-1:0] influence;

  // window state
  logic signed [15:0]      ring [LAG];
  logic signed [15:0]      ring_q;
  logic [LAG_W-1:0]        ring_position;
  logic signed [SUM_W-1:0] window_sum;
  logic [SQ_W-1:0]         window_square_sum;
  logic signed [15:0]      previous_filtered;
  logic [FILL_W-1:0]       fill_count;

  // per-item working registers
  logic signed [15:0]      y;
  logic                    warm;
  logic signed [D_W-1:0]   d;
  logic [2*A_W-1:0]        s2;
  logic [2*A_W-1:0]        var_w;
  logic [B_W-1:0]          tl;
  logic [ACC_W-1:0]        rhs;
  logic [2*A_W-1:0]        d2;
  logic                    flagged;
  logic signed [15:0]      f;
  logic [B_W-1:0]          fsq;

  // shared multiplier
  mul_ctrl_t        mul_ctrl;
  logic [A_W-1:0]   mul_a;
  logic [B_W-1:0]   mul_b;
  logic [ACC_W-1:0] acc;

  szpd_mul_unit u_mul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .a    (mul_a),
    .b    (mul_b),
    .acc  (acc)
  );

  // derived values
  logic                    accept;
  logic                    commit;
  logic [SUM_W-1:0]        sum_mag;
  logic [2*A_W-1:0]        ss_wide;
  logic [D_W-1:0]          d_mag;
  logic signed [16:0]      diff;
  logic [16:0]             diff_mag;
  logic [INF_W-1:0]        inf_eff;
  logic signed [15:0]      old;
  logic [15:0]             f_mag;
  logic [15:0]             old_mag;
  logic signed [BL_W-1:0]  blend_sum;
  logic signed [BL_W-1:0]  blend_prod;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  assign sum_mag  = window_sum[SUM_W-1] ? $unsigned(-window_sum) : $unsigned(window_sum);
  assign ss_wide  = (2*A_W)'(window_square_sum);
  assign d_mag    = d[D_W-1] ? $unsigned(-d) : $unsigned(d);
  assign diff     = 17'(y) - 17'(previous_filtered);
  assign diff_mag = diff[16] ? $unsigned(-diff) : $unsigned(diff);
  assign inf_eff  = (influence > INFLUENCE_FULL) ? INFLUENCE_FULL : influence;
  assign old      = warm ? 16'sd0 : ring_q;
  assign f_mag    = f[15] ? $unsigned(-f) : $unsigned(f);
  assign old_mag  = old[15] ? $unsigned(-old) : $unsigned(old);

  // blend: prev*256 + influence*(y - prev) + 128, then floor by 256
  assign blend_prod = diff[16] ? -$signed({3'b000, acc[A_W-1:0]})
                               : $signed({3'b000, acc[A_W-1:0]});
  assign blend_sum  = $signed({{3{previous_filtered[15]}}, previous_filtered, 8'h00})
                    + blend_prod + BL_W'(128);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = (fill_count < FILL_W'(LAG)) ? S_FILT : S_SQS;
      S_SQS:    state_next = S_LSS_LO;
      S_LSS_LO: state_next = S_LSS_HI;
      S_LSS_HI: state_next = S_T2;
      S_T2:     state_next = S_TL;
      S_TL:     state_next = S_RHS_LO;
      S_RHS_LO: state_next = S_RHS_HI;
      S_RHS_HI: state_next = S_D2;
      S_D2:     state_next = S_LHS_LO;
      S_LHS_LO: state_next = S_LHS_HI;
      S_LHS_HI: state_next = S_BLEND;
      S_BLEND:  state_next = S_FILT;
      S_FILT:   state_next = S_FSQ;
      S_FSQ:    state_next = S_OSQ;
      S_OSQ:    state_next = S_DONE;
      S_DONE:   if (commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_SQS: begin
        mul_ctrl.en = 1'b1;
        mul_a       = A_W'(sum_mag);
        mul_b       = B_W'(sum_mag);
      end
      S_LSS_LO: begin
        mul_ctrl.en = 1'b1;
        mul_a       = ss_wide[A_W-1:0];
        mul_b       = B_W'(LAG);
      end
      S_LSS_HI: begin
        mul_ctrl    = '{en: 1'b1, hi: 1'b1};
        mul_a       = ss_wide[2*A_W-1:A_W];
        mul_b       = B_W'(LAG);
      end
      S_T2: begin
        mul_ctrl.en = 1'b1;
        mul_a       = A_W'(threshold);
        mul_b       = B_W'(threshold);
      end
      S_TL: begin
        mul_ctrl.en = 1'b1;
        mul_a       = acc[A_W-1:0];
        mul_b       = B_W'(LAG);
      end
      S_RHS_LO: begin
        mul_ctrl.en = 1'b1;
        mul_a       = var_w[A_W-1:0];
        mul_b       = acc[B_W-1:0];
      end
      S_RHS_HI: begin
        mul_ctrl    = '{en: 1'b1, hi: 1'b1};
        mul_a       = var_w[2*A_W-1:A_W];
        mul_b       = tl;
      end
      S_D2: begin
        mul_ctrl.en = 1'b1;
        mul_a       = A_W'(d_mag);
        mul_b       = B_W'(d_mag);
      end
      S_LHS_LO: begin
        mul_ctrl.en = 1'b1;
        mul_a       = acc[A_W-1:0];
        mul_b       = B_W'(LAG - 1);
      end
      S_LHS_HI: begin
        mul_ctrl    = '{en: 1'b1, hi: 1'b1};
        mul_a       = d2[2*A_W-1:A_W];
        mul_b       = B_W'(LAG - 1);
      end
      S_BLEND: begin
        mul_ctrl.en = 1'b1;
        mul_a       = A_W'(diff_mag);
        mul_b       = B_W'(inf_eff);
      end
      S_FSQ: begin
        mul_ctrl.en = 1'b1;
        mul_a       = A_W'(f_mag);
        mul_b       = B_W'(f_mag);
      end
      S_OSQ: begin
        mul_ctrl.en = 1'b1;
        mul_a       = A_W'(old_mag);
        mul_b       = B_W'(old_mag);
      end
      default: begin
        mul_ctrl = '0;
      end
    endcase
  end

  // capture of intermediate results
  always_ff @(posedge clk) begin
    if (accept) begin
      y       <= sample;
      warm    <= (fill_count < FILL_W'(LAG));
      flagged <= 1'b0;
    end
    case (state)
      S_SQS:    d <= LAG_SD * D_W'(y) - D_W'(window_sum);
      S_LSS_LO: s2 <= acc[2*A_W-1:0];
      S_T2:     var_w <= (acc[2*A_W-1:0] > s2) ? acc[2*A_W-1:0] - s2 : '0;
      S_RHS_LO: tl <= acc[B_W-1:0];
      S_D2:     rhs <= acc;
      S_LHS_LO: d2 <= acc[2*A_W-1:0];
      S_BLEND:  flagged <= {acc, 16'h0000} > CMP_W'(rhs);
      S_FILT:   f <= flagged ? blend_sum[23:8] : y;
      S_OSQ:    fsq <= acc[B_W-1:0];
      default: begin
      end
    endcase
  end

  // window ring: one write port, registered read at the current position
  always_ff @(posedge clk) begin
    if (commit) begin
      ring[ring_position] <= f;
    end
    ring_q <= ring[ring_position];
  end

  // window state update at the end of an item
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position     <= '0;
      window_sum        <= '0;
      window_square_sum <= '0;
      previous_filtered <= '0;
      fill_count        <= '0;
    end else if (commit) begin
      ring_position     <= (ring_position == LAG_W'(LAG - 1)) ? '0 : ring_position + 1'b1;
      window_sum        <= window_sum + SUM_W'(f) - SUM_W'(old);
      window_square_sum <= window_square_sum + SQ_W'(fsq) - SQ_W'(acc[B_W-1:0]);
      previous_filtered <= f;
      if (fill_count < FILL_W'(LAG)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      warming_up <= warm;
      if (flagged) begin
        peak_signal <= d[D_W-1] ? -2'sd1 : 2'sd1;
      end else begin
        peak_signal <= 2'sd0;
      end
    end
  end

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      influence <= INFLUENCE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_THRESHOLD: threshold <= pwdata[THR_W-1:0];
        REG_INFLUENCE: influence <= pwdata[INF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = 32'(threshold);
      REG_INFLUENCE: prdata = 32'(influence);
      default:       prdata = '0;
    endcase
  end

  // checks
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("result not presented after item completion");

  a_position_holds: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(ring_position))
    else $error("ring position moved outside item completion");

  a_warm_no_signal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && warming_up) |-> (peak_signal == 2'sd0))
    else $error("signal raised during warm-up");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SQS || state == S_FILT))
    else $error("accepted item did not start processing");

endmodule
